### rtl/kmqt_pkg.sv
package kmqt_pkg;

  localparam int MODE_W    = 2;
  localparam int KEY_W     = 32;
  localparam int MSG_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int IDX_W     = 4;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECV   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BADKEY   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EXISTS   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOFREE   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_RDATA
  } state_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic load_rd;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic recv_hit;
  } stat_t;

endpackage

### rtl/kmqt_ram.sv
module kmqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/kmqt_ctrl.sv
module kmqt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  kmqt_pkg::stat_t stat,
  output kmqt_pkg::cmd_t  cmd
);

  import kmqt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (stat.slot_free) begin
          cmd.commit = 1'b1;
          state_next = stat.recv_hit ? ST_RDATA : ST_IDLE;
        end
      end
      ST_RDATA: begin
        cmd.load_rd = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/kmqt_dp.sv
module kmqt_dp #(
  parameter int NUM_BOXES = 16,
  parameter int BOX_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [kmqt_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [kmqt_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [kmqt_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [kmqt_pkg::M_TUSER_W-1:0]   m_tuser,
  input  kmqt_pkg::cmd_t                   cmd,
  output kmqt_pkg::stat_t                  stat
);

  import kmqt_pkg::*;

  localparam int BW    = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int PW    = (BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1;
  localparam int CW    = $clog2(BOX_DEPTH + 1);
  localparam int DEPTH = NUM_BOXES * BOX_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // request
  logic [MODE_W-1:0] req_mode;
  logic [KEY_W-1:0]  req_key;
  logic [MSG_W-1:0]  req_msg;

  // box table
  logic [NUM_BOXES-1:0] box_used;
  logic [KEY_W-1:0]     box_key   [NUM_BOXES];
  logic [PW-1:0]        rd_ptr    [NUM_BOXES];
  logic [PW-1:0]        wr_ptr    [NUM_BOXES];
  logic [CW-1:0]        fill      [NUM_BOXES];

  // result
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]    out_idx;
  logic [MSG_W-1:0]    out_msg;

  logic [NUM_BOXES-1:0] hit;
  logic                 found;
  logic                 any_free;
  logic [BW-1:0]        match_idx;
  logic [BW-1:0]        free_idx;
  logic                 key_ok;
  logic [STATUS_W-1:0]  status;
  logic                 do_create;
  logic                 do_send;
  logic                 do_recv;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [MSG_W-1:0]     ram_rdata;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(BOX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode <= s_tuser[MODE_W-1:0];
      req_key  <= s_tdata[KEY_W-1:0];
      req_msg  <= s_tdata[KEY_W+MSG_W-1:KEY_W];
    end
  end

  always_comb begin
    found     = 1'b0;
    any_free  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = NUM_BOXES - 1; i >= 0; i--) begin
      hit[i] = box_used[i] && (box_key[i] == req_key);
      if (hit[i]) begin
        found     = 1'b1;
        match_idx = BW'(i);
      end
      if (!box_used[i]) begin
        any_free = 1'b1;
        free_idx = BW'(i);
      end
    end
  end

  assign key_ok = !req_key[KEY_W-1] && (req_key != '0);

  always_comb begin
    status    = STAT_BADKEY;
    do_create = 1'b0;
    do_send   = 1'b0;
    do_recv   = 1'b0;
    case (req_mode)
      MODE_CREATE: begin
        if (!key_ok) begin
          status = STAT_BADKEY;
        end else if (found) begin
          status = STAT_EXISTS;
        end else if (!any_free) begin
          status = STAT_NOFREE;
        end else begin
          status    = STAT_OK;
          do_create = 1'b1;
        end
      end
      MODE_SEND: begin
        if (!found) begin
          status = STAT_NOTFOUND;
        end else if (fill[match_idx] == CW'(BOX_DEPTH)) begin
          status = STAT_FULL;
        end else begin
          status  = STAT_OK;
          do_send = 1'b1;
        end
      end
      MODE_RECV: begin
        if (!found) begin
          status = STAT_NOTFOUND;
        end else if (fill[match_idx] == '0) begin
          status = STAT_EMPTY;
        end else begin
          status  = STAT_OK;
          do_recv = 1'b1;
        end
      end
      default: begin
        status = STAT_BADKEY;
      end
    endcase
  end

  assign stat.slot_free = !out_valid || m_tready;
  assign stat.recv_hit  = do_recv;

  assign wr_addr = AW'(match_idx) * AW'(BOX_DEPTH) + AW'(wr_ptr[match_idx]);
  assign rd_addr = AW'(match_idx) * AW'(BOX_DEPTH) + AW'(rd_ptr[match_idx]);

  kmqt_ram #(
    .WIDTH (MSG_W),
    .DEPTH (DEPTH)
  ) msg_ram (
    .clk   (clk),
    .we    (cmd.commit && do_send),
    .waddr (wr_addr),
    .wdata (req_msg),
    .re    (cmd.commit && do_recv),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      box_used <= '0;
      for (int i = 0; i < NUM_BOXES; i++) begin
        box_key[i] <= '0;
        rd_ptr[i]  <= '0;
        wr_ptr[i]  <= '0;
        fill[i]    <= '0;
      end
    end else if (cmd.commit) begin
      if (do_create) begin
        box_used[free_idx] <= 1'b1;
        box_key[free_idx]  <= req_key;
        rd_ptr[free_idx]   <= '0;
        wr_ptr[free_idx]   <= '0;
        fill[free_idx]     <= '0;
      end
      if (do_send) begin
        wr_ptr[match_idx] <= ptr_inc(wr_ptr[match_idx]);
        fill[match_idx]   <= fill[match_idx] + 1'b1;
      end
      if (do_recv) begin
        rd_ptr[match_idx] <= ptr_inc(rd_ptr[match_idx]);
        fill[match_idx]   <= fill[match_idx] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.commit && !do_recv) || cmd.load_rd) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !do_recv) begin
      out_status <= status;
      out_idx    <= do_create ? IDX_W'(free_idx) : '0;
      out_msg    <= '0;
    end else if (cmd.load_rd) begin
      out_status <= STAT_OK;
      out_idx    <= '0;
      out_msg    <= ram_rdata;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(M_TDATA_W - IDX_W - MSG_W){1'b0}}, out_msg, out_idx};

endmodule

### rtl/keyed_mailbox_queue_table.sv
// Keyed mailbox queue table.
//
// Slave stream carries requests: s_tuser holds the mode (create, send,
// receive), s_tdata the key and the message word. Master stream carries one
// response per request: m_tuser holds the status, m_tdata the allocated slot
// and the popped word.
//
// A request is registered in the idle state; in the work state the key is
// matched against all boxes in parallel, and the table and message memory
// are updated there once the output register is free. A successful receive
// then passes through a read state for the registered read of the message
// memory. One request is in flight at a time.
//
// Reset empties every box and clears all keys and pointers; the message
// memory is not cleared. A response waits in the output register while
// m_tready is low; the next request may be accepted meanwhile, but is held
// before its table update until the output register is free.
module keyed_mailbox_queue_table #(
  parameter int NUM_BOXES = 16,
  parameter int BOX_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [kmqt_pkg::S_TDATA_W-1:0] s_tdata,  // key[31:0], msg_in[63:32]
  input  logic [kmqt_pkg::S_TUSER_W-1:0] s_tuser,  // mode[1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [kmqt_pkg::M_TDATA_W-1:0] m_tdata,  // box_index[3:0], msg_out[35:4], zero
  output logic [kmqt_pkg::M_TUSER_W-1:0] m_tuser   // status[2:0]
);

  import kmqt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kmqt_ctrl ctrl_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kmqt_dp #(
    .NUM_BOXES (NUM_BOXES),
    .BOX_DEPTH (BOX_DEPTH)
  ) dp_i (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

### rtl/kmqt_chk.sv
module kmqt_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [kmqt_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [kmqt_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [kmqt_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [kmqt_pkg::M_TUSER_W-1:0] m_tuser
);

  import kmqt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("response dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("response present straight after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 3'd7))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
    else $error("failed request returns data");

endmodule

bind keyed_mailbox_queue_table kmqt_chk chk_i (.*);

### dv/tb_keyed_mailbox_queue_table.sv
module tb_keyed_mailbox_queue_table;
  import kmqt_pkg::*;

  localparam int BOXES = 16;
  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
    logic [MSG_W-1:0]    word;
  } mbox_resp_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // key[31:0], msg_in[63:32]
  logic [S_TUSER_W-1:0] s_tuser;   // mode[1:0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // box_index[3:0], msg_out[35:4], zero
  logic [M_TUSER_W-1:0] m_tuser;   // status[2:0]

  // predicted mailbox table
  bit                 box_used [BOXES];
  logic [KEY_W-1:0]   box_key [BOXES];
  int                 head_ptr [BOXES];
  int                 tail_ptr [BOXES];
  int                 box_fill [BOXES];
  logic [MSG_W-1:0]   box_store [BOXES][DEPTH];

  mbox_resp_t pending_resps[$];
  mbox_resp_t head_resp;
  int         mismatches;
  int         idle_pct;
  int         hold_len;
  int         stall_cycles;

  keyed_mailbox_queue_table #(
    .NUM_BOXES(BOXES),
    .BOX_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic mbox_resp_t predict_mailbox(input logic [MODE_W-1:0] mode,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [MSG_W-1:0] word);
    mbox_resp_t r;
    int         hit;
    r = '0;
    r.status = STAT_BADKEY;
    hit = -1;
    for (int b = BOXES - 1; b >= 0; b--) begin
      if (box_used[b] && box_key[b] == key) hit = b;
    end
    case (mode)
      MODE_CREATE: begin
        if (key == '0 || key[KEY_W-1]) begin
          r.status = STAT_BADKEY;
        end else if (hit >= 0) begin
          r.status = STAT_EXISTS;
        end else begin
          r.status = STAT_NOFREE;
          for (int b = 0; b < BOXES; b++) begin
            if (!box_used[b] && r.status == STAT_NOFREE) begin
              box_used[b] = 1'b1;
              box_key[b]  = key;
              head_ptr[b] = 0;
              tail_ptr[b] = 0;
              box_fill[b] = 0;
              r.slot      = b[IDX_W-1:0];
              r.status    = STAT_OK;
            end
          end
        end
      end
      MODE_SEND: begin
        if (hit < 0) begin
          r.status = STAT_NOTFOUND;
        end else if (box_fill[hit] >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          box_store[hit][tail_ptr[hit]] = word;
          tail_ptr[hit] = (tail_ptr[hit] + 1) % DEPTH;
          box_fill[hit]++;
          r.status = STAT_OK;
        end
      end
      MODE_RECV: begin
        if (hit < 0) begin
          r.status = STAT_NOTFOUND;
        end else if (box_fill[hit] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.word = box_store[hit][head_ptr[hit]];
          head_ptr[hit] = (head_ptr[hit] + 1) % DEPTH;
          box_fill[hit]--;
          r.status = STAT_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_live_key();
    int tries;
    int b;
    tries = 0;
    b = $urandom_range(0, BOXES - 1);
    while (!box_used[b] && tries < 4 * BOXES) begin
      b = $urandom_range(0, BOXES - 1);
      tries++;
    end
    return box_used[b] ? box_key[b] : 32'd1;
  endfunction

  function automatic logic [KEY_W-1:0] pick_noise_key();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return {1'b1, 31'($urandom)};
      2: return 32'($urandom_range(1, 32'h7fff_ffff));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic int live_boxes();
    int n;
    n = 0;
    for (int b = 0; b < BOXES; b++) n += box_used[b];
    return n;
  endfunction

  // called and returns on a falling edge
  task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                               input logic [MSG_W-1:0] word);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {word, key};
    do @(posedge clk); while (!s_tready);
    pending_resps.push_back(predict_mailbox(mode, key, word));
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_resps.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, 32'(m_tuser));
      end else begin
        head_resp = pending_resps.pop_front();
        if (m_tuser[STATUS_W-1:0] !== head_resp.status)
          flag_mismatch("status", 32'(head_resp.status), 32'(m_tuser[STATUS_W-1:0]));
        if (m_tdata[IDX_W-1:0] !== head_resp.slot)
          flag_mismatch("box_index", 32'(head_resp.slot), 32'(m_tdata[IDX_W-1:0]));
        if (m_tdata[IDX_W+MSG_W-1:IDX_W] !== head_resp.word)
          flag_mismatch("msg_out", head_resp.word, m_tdata[IDX_W+MSG_W-1:IDX_W]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random back-pressure, plus a long hold when asked
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_len != 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic test_directed();
    issue_request(MODE_SEND, 32'd5, 32'h1234_5678);
    issue_request(MODE_RECV, 32'd5, '0);
    issue_request(MODE_NOP, 32'd5, 32'hffff_ffff);
    issue_request(MODE_CREATE, '0, '0);
    issue_request(MODE_CREATE, 32'h8000_0000, '0);
    issue_request(MODE_CREATE, 32'hffff_ffff, '0);
    issue_request(MODE_CREATE, 32'd1, '0);
    issue_request(MODE_CREATE, 32'h7fff_ffff, 32'hffff_ffff);
    issue_request(MODE_CREATE, 32'd1, '0);
    issue_request(MODE_RECV, 32'd1, '0);
    issue_request(MODE_SEND, 32'd1, '0);
    issue_request(MODE_SEND, 32'd1, 32'hffff_ffff);
    issue_request(MODE_SEND, 32'h7fff_ffff, 32'h8000_0000);
    issue_request(MODE_SEND, 32'h8000_0000, 32'h7fff_ffff);
    issue_request(MODE_RECV, 32'hffff_ffff, '0);
    issue_request(MODE_SEND, '0, 32'h5555_aaaa);
    issue_request(MODE_RECV, 32'd1, '0);
    issue_request(MODE_RECV, 32'd1, '0);
    issue_request(MODE_RECV, 32'h7fff_ffff, '0);
    issue_request(MODE_RECV, 32'h7fff_ffff, '0);
    issue_request(MODE_NOP, 32'd1, '0);
    issue_request(MODE_NOP, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_fill_table();
    while (live_boxes() < BOXES) begin
      if ($urandom_range(0, 4) == 0)
        issue_request(MODE_CREATE, pick_live_key(), 32'($urandom));
      else
        issue_request(MODE_CREATE, 32'($urandom_range(1, 32'h7fff_ffff)), 32'($urandom));
    end
    repeat (3) issue_request(MODE_CREATE, 32'($urandom_range(1, 32'h7fff_ffff)), '0);
    issue_request(MODE_CREATE, pick_live_key(), '0);
  endtask

  // fill a box up to or past full, drain it to or past empty, then churn to wrap the pointers
  task automatic test_full_and_wrap();
    logic [KEY_W-1:0] k;
    repeat (6) begin
      k = pick_live_key();
      repeat ($urandom_range(DEPTH, DEPTH + 3)) issue_request(MODE_SEND, k, 32'($urandom));
      repeat ($urandom_range(DEPTH, DEPTH + 3)) issue_request(MODE_RECV, k, 32'($urandom));
      repeat (8) begin
        repeat ($urandom_range(1, 5)) issue_request(MODE_SEND, k, 32'($urandom));
        repeat ($urandom_range(1, 5)) issue_request(MODE_RECV, k, 32'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    repeat (40) begin
      if ($urandom_range(0, 1) == 0)
        issue_request(MODE_SEND, pick_live_key(), 32'($urandom));
      else
        issue_request(MODE_RECV, pick_live_key(), 32'($urandom));
    end
  endtask

  task automatic test_random_mix(input int chunks, input int busy_pct);
    int r;
    int send_bias;
    for (int c = 0; c < chunks; c++) begin
      idle_pct  = (c % 3 == 2) ? 0 : busy_pct;
      send_bias = (c % 2 == 0) ? 50 : 30;
      repeat (100) begin
        r = $urandom_range(0, 99);
        if (r < send_bias)
          issue_request(MODE_SEND, pick_live_key(), 32'($urandom));
        else if (r < 80)
          issue_request(MODE_RECV, pick_live_key(), 32'($urandom));
        else if (r < 85)
          issue_request(MODE_CREATE, ($urandom_range(0, 1) == 0) ? pick_live_key()
                                                               : pick_noise_key(),
                        32'($urandom));
        else if (r < 89)
          issue_request(MODE_NOP, 32'($urandom), 32'($urandom));
        else
          issue_request(($urandom_range(0, 1) == 0) ? MODE_SEND : MODE_RECV,
                        pick_noise_key(), 32'($urandom));
      end
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    mismatches = 0;
    hold_len   = 0;
    idle_pct   = 25;
    for (int b = 0; b < BOXES; b++) begin
      box_used[b] = 1'b0;
      box_key[b]  = '0;
      head_ptr[b] = 0;
      tail_ptr[b] = 0;
      box_fill[b] = 0;
    end
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_fill_table();
    test_full_and_wrap();
    test_backpressure();
    test_random_mix(13, 25);
    idle_pct = 0;
    test_random_mix(1, 0);

    s_tvalid <= 1'b0;
    while (pending_resps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_resps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
